FILE: rtl/lat_hist_pkg.sv
`default_nettype none

package lat_hist_pkg;

   // Field widths fixed by the interface.
   localparam int SAMPLE_W  = 48;
   localparam int COUNT_W   = 32;
   localparam int SUM_W     = 64;
   localparam int INDEX_W   = 8;
   localparam int SPB_W     = 32;
   localparam int CSR_ADDR_W = 1;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 264;

   // Default number of bucket slots.
   localparam int DEF_BUCKET_SLOTS = 256;

   // Serial divider widths: the dividend holds 2*sample + p or 2*bin + n,
   // the divisor holds 2*p or 2*n.
   localparam int NUM_W = 51;
   localparam int DEN_W = 33;
   localparam int CNT_W = $clog2(NUM_W);

   // Commands carried in the request user field.
   typedef enum logic [1:0] {
      CMD_RECORD = 2'd0,
      CMD_READ   = 2'd1,
      CMD_STATS  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] REG_SPB = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_NB  = 1'd1;

   // Divider request and response.
   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quo;
   } div_rsp_type;

endpackage

`default_nettype wire

FILE: rtl/latency_histogram_top.sv
// Latency histogram with median search.
// Requests arrive on the req_ stream: req_tuser carries the command (record,
// read bucket, report statistics), req_tdata the sample and bucket index.
// A record transaction bins the sample into a bucket with a bit-serial
// divider and produces no response. A read or statistics transaction produces
// one response on the rsp_ stream. Configuration is written through csr_; the
// user must write it only while the block is idle, which the block does not enforce.
// A record bins its sample in one 51-step pass of the shared serial divider when
// the bin lands in a slot and in two when it overflows into the last slot, then
// does a read-modify-write of the bucket store. A read fetches one bucket from
// the store; a statistics report walks the store with one read per cycle,
// stopping at the median slot or at the last slot. One transaction is worked on
// at a time.
// After reset the bucket store goes through a clearing pass, during
// which req_tready stays low. A response waits in an output register while
// rsp_tready is low; the next request is accepted meanwhile and its own
// response waits until that register is free.
`default_nettype none

module latency_histogram_top
   import lat_hist_pkg::*;
#(
   parameter int BUCKET_SLOTS = DEF_BUCKET_SLOTS
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // csr_ configuration write port
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [SPB_W-1:0]      csr_wdata,
   // req_tdata: sample[47:0], bucket_index[55:48]
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: command[1:0]
   input  wire logic [1:0]            req_tuser,
   // rsp_tdata: bucket_count[31:0], sample_count[63:32], overflow_count[95:64],
   // sample_sum[159:96], min_sample[207:160], max_sample[255:208],
   // median_bucket[263:256]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int IDX_W = $clog2(BUCKET_SLOTS);
   localparam int ACC_W = COUNT_W + IDX_W;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_DIV1 = 9'b000000010,
      ST_DIV2 = 9'b000000100,
      ST_RD   = 9'b000001000,
      ST_WR   = 9'b000010000,
      ST_RDQ  = 9'b000100000,
      ST_GET  = 9'b001000000,
      ST_WALK = 9'b010000000,
      ST_PUSH = 9'b100000000
   } state_type;

   state_type              state_ff, state_in;
   logic [SPB_W-1:0]       spb_ff, spb_in;
   logic [INDEX_W-1:0]     nb_ff, nb_in;
   logic [COUNT_W-1:0]     total_ff, total_in;
   logic [COUNT_W-1:0]     ovf_ff, ovf_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SAMPLE_W-1:0]    min_ff, min_in;
   logic [SAMPLE_W-1:0]    max_ff, max_in;
   logic [IDX_W-1:0]       addr_ff, addr_in;
   logic [NUM_W-1:0]       weight_ff, weight_in;
   logic                   idx_ok_ff, idx_ok_in;
   logic                   stats_ff, stats_in;
   logic [COUNT_W-1:0]     bucket_ff, bucket_in;
   logic [INDEX_W-1:0]     median_ff, median_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [COUNT_W-2:0]     half_ff, half_in;
   logic [IDX_W:0]         walk_addr_ff, walk_addr_in;
   logic                   walk_vld_ff, walk_vld_in;
   logic [IDX_W-1:0]       walk_idx_ff, walk_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [SAMPLE_W-1:0]    req_sample;
   logic [15:0]            req_idx16;
   cmd_type                req_cmd;
   logic [SPB_W-1:0]       p_eff;
   logic [15:0]            last16;
   logic [15:0]            n16;
   logic [15:0]            walk_idx16;
   logic [IDX_W-1:0]       last_slot;
   logic                   mem_rd_en;
   logic [IDX_W-1:0]       mem_rd_addr;
   logic [COUNT_W-1:0]     mem_rd_data;
   logic                   mem_wr_en;
   logic [COUNT_W-1:0]     mem_wr_data;
   logic                   clr_busy;
   logic [COUNT_W+20-1:0]  upd_sum;
   logic [ACC_W-1:0]       acc_sum;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   lat_hist_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   lat_hist_mem #(
      .SLOTS (BUCKET_SLOTS)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (mem_rd_en),
      .rd_addr  (mem_rd_addr),
      .rd_data  (mem_rd_data),
      .wr_en    (mem_wr_en),
      .wr_addr  (addr_ff),
      .wr_data  (mem_wr_data),
      .clr_busy (clr_busy)
   );

   // Request fields and derived configuration.
   always_comb begin
      req_sample = req_tdata[SAMPLE_W-1:0];
      req_idx16  = 16'(req_tdata[REQ_DATA_W-1:SAMPLE_W]);
      req_cmd    = cmd_type'(req_tuser);
      p_eff      = (spb_ff == '0) ? SPB_W'(1) : spb_ff;
      last16     = (16'(nb_ff) > 16'(BUCKET_SLOTS - 1)) ? 16'(BUCKET_SLOTS - 1)
                                                       : 16'(nb_ff);
      n16        = last16 + 16'd1;
      last_slot  = last16[IDX_W-1:0];
      walk_idx16 = 16'(walk_idx_ff);
      req_tready = (state_ff == ST_IDLE) && !clr_busy;
   end

   // Configuration writes.
   always_comb begin
      spb_in = spb_ff;
      nb_in  = nb_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_SPB: spb_in = csr_wdata;
            REG_NB:  nb_in  = csr_wdata[INDEX_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturating bucket update and the median walk accumulator.
   always_comb begin
      upd_sum     = (COUNT_W+20)'(mem_rd_data) + (COUNT_W+20)'(weight_ff);
      mem_wr_data = (upd_sum > (COUNT_W+20)'({COUNT_W{1'b1}})) ? {COUNT_W{1'b1}}
                                                              : upd_sum[COUNT_W-1:0];
      acc_sum     = acc_ff + ACC_W'(mem_rd_data);
   end

   // Main sequencer.
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      addr_in      = addr_ff;
      weight_in    = weight_ff;
      idx_ok_in    = idx_ok_ff;
      stats_in     = stats_ff;
      bucket_in    = bucket_ff;
      median_in    = median_ff;
      acc_in       = acc_ff;
      half_in      = half_ff;
      walk_addr_in = walk_addr_ff;
      walk_vld_in  = 1'b0;
      walk_idx_in  = walk_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      div_req      = '0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = addr_ff;
      mem_wr_en    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               case (req_cmd)
                  CMD_RECORD: begin
                     if (req_sample > max_ff) max_in = req_sample;
                     if (req_sample < min_ff) min_in = req_sample;
                     sum_in = sum_ff + SUM_W'(req_sample);
                     if (total_ff != {COUNT_W{1'b1}}) total_in = total_ff + COUNT_W'(1);
                     div_req.start = 1'b1;
                     div_req.num   = NUM_W'({req_sample, 1'b0}) + NUM_W'(p_eff);
                     div_req.den   = DEN_W'({p_eff, 1'b0});
                     state_in      = ST_DIV1;
                  end
                  CMD_READ: begin
                     addr_in   = req_idx16[IDX_W-1:0];
                     idx_ok_in = req_idx16 <= last16;
                     stats_in  = 1'b0;
                     median_in = '0;
                     state_in  = ST_RDQ;
                  end
                  CMD_STATS: begin
                     half_in      = total_ff[COUNT_W-1:1];
                     acc_in       = '0;
                     walk_addr_in = '0;
                     stats_in     = 1'b1;
                     bucket_in    = '0;
                     state_in     = ST_WALK;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               if (div_rsp.quo <= NUM_W'(last16)) begin
                  addr_in   = div_rsp.quo[IDX_W-1:0];
                  weight_in = NUM_W'(1);
                  state_in  = ST_RD;
               end else begin
                  // Overflow: weight is the bin divided by n, rounded.
                  if (ovf_ff != {COUNT_W{1'b1}}) ovf_in = ovf_ff + COUNT_W'(1);
                  addr_in       = last_slot;
                  div_req.start = 1'b1;
                  div_req.num   = {div_rsp.quo[NUM_W-2:0], 1'b0} + NUM_W'(n16);
                  div_req.den   = DEN_W'({n16, 1'b0});
                  state_in      = ST_DIV2;
               end
            end
         end
         ST_DIV2: begin
            if (div_rsp.done) begin
               weight_in = div_rsp.quo;
               state_in  = ST_RD;
            end
         end
         ST_RD: begin
            mem_rd_en = 1'b1;
            state_in  = ST_WR;
         end
         ST_WR: begin
            mem_wr_en = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_RDQ: begin
            mem_rd_en = 1'b1;
            state_in  = ST_GET;
         end
         ST_GET: begin
            bucket_in = idx_ok_ff ? mem_rd_data : '0;
            state_in  = ST_PUSH;
         end
         ST_WALK: begin
            // Issue one read per cycle; check the data of the previous read.
            mem_rd_addr  = walk_addr_ff[IDX_W-1:0];
            mem_rd_en    = walk_addr_ff <= (IDX_W+1)'(last16);
            walk_vld_in  = mem_rd_en;
            walk_idx_in  = walk_addr_ff[IDX_W-1:0];
            walk_addr_in = walk_addr_ff + (IDX_W+1)'(1);
            if (walk_vld_ff) begin
               acc_in = acc_sum;
               if (acc_sum >= ACC_W'(half_ff)) begin
                  median_in   = walk_idx16[INDEX_W-1:0];
                  walk_vld_in = 1'b0;
                  state_in    = ST_PUSH;
               end else if (walk_idx_ff == last_slot) begin
                  median_in   = '0;
                  walk_vld_in = 1'b0;
                  state_in    = ST_PUSH;
               end
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {median_ff,
                               stats_ff ? max_ff   : {SAMPLE_W{1'b0}},
                               stats_ff ? min_ff   : {SAMPLE_W{1'b0}},
                               stats_ff ? sum_ff   : {SUM_W{1'b0}},
                               stats_ff ? ovf_ff   : {COUNT_W{1'b0}},
                               stats_ff ? total_ff : {COUNT_W{1'b0}},
                               bucket_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         spb_ff       <= SPB_W'(1);
         nb_ff        <= {INDEX_W{1'b1}};
         total_ff     <= '0;
         ovf_ff       <= '0;
         sum_ff       <= '0;
         min_ff       <= {SAMPLE_W{1'b1}};
         max_ff       <= '0;
         walk_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         spb_ff       <= spb_in;
         nb_ff        <= nb_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         sum_ff       <= sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         walk_vld_ff  <= walk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff      <= addr_in;
      weight_ff    <= weight_in;
      idx_ok_ff    <= idx_ok_in;
      stats_ff     <= stats_in;
      bucket_ff    <= bucket_in;
      median_ff    <= median_in;
      acc_ff       <= acc_in;
      half_ff      <= half_in;
      walk_addr_ff <= walk_addr_in;
      walk_idx_ff  <= walk_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/lat_hist_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
module lat_hist_div
   import lat_hist_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  div_req_type      div_req,
   output div_rsp_type      div_rsp
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // One shift-subtract step; quotient bits enter the dividend register.
   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], fits};
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = num_ff;

endmodule

`default_nettype wire

FILE: rtl/lat_hist_mem.sv
`default_nettype none

// Bucket count store with a clearing pass after reset.
module lat_hist_mem
   import lat_hist_pkg::*;
#(
   parameter int SLOTS = DEF_BUCKET_SLOTS,
   localparam int ADDR_W = $clog2(SLOTS)
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               rd_en,
   input  wire logic [ADDR_W-1:0]  rd_addr,
   output logic      [COUNT_W-1:0] rd_data,
   input  wire logic               wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire logic [COUNT_W-1:0] wr_data,
   output logic                    clr_busy
);

   logic [COUNT_W-1:0] mem [SLOTS];
   logic [COUNT_W-1:0] rd_data_ff;
   logic               clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;

   // The clearing pass writes one zero per cycle until the last slot.
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(SLOTS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Single write port and a registered read port.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule

`default_nettype wire

FILE: tb/tb_latency_histogram_top.sv
`default_nettype none

module tb_latency_histogram_top;

   timeunit 1ns;
   timeprecision 1ps;

   import lat_hist_pkg::*;

   // Cycles without any transaction before the run is declared hung.
   localparam int STALL_LIMIT   = 4000;
   // Quiet time before a register write, longer than an overflowing record.
   localparam int SETTLE_CYCLES = 250;

   // Expected response fields, listed from the lowest field of rsp_tdata up.
   typedef struct packed {
      bit [COUNT_W-1:0]  bucket_count;
      bit [COUNT_W-1:0]  sample_count;
      bit [COUNT_W-1:0]  overflow_count;
      bit [SUM_W-1:0]    sample_sum;
      bit [SAMPLE_W-1:0] min_sample;
      bit [SAMPLE_W-1:0] max_sample;
      bit [INDEX_W-1:0]  median_bucket;
   } hist_reply_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [SPB_W-1:0]      csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Predicted histogram state and configuration.
   bit [COUNT_W-1:0]  slot_count [DEF_BUCKET_SLOTS];
   bit [COUNT_W-1:0]  recorded_total;
   bit [COUNT_W-1:0]  overflow_total;
   bit [SUM_W-1:0]    sample_total;
   bit [SAMPLE_W-1:0] min_seen;
   bit [SAMPLE_W-1:0] max_seen;
   bit [SPB_W-1:0]    bucket_width;
   bit [INDEX_W-1:0]  last_index;

   hist_reply_t pending_replies [$];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          steady_flow = 1'b0;

   latency_histogram_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock generation.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Saturating 32-bit add.
   function automatic bit [COUNT_W-1:0] sat_add(bit [COUNT_W-1:0] a, bit [63:0] b);
      bit [64:0] t;
      t = {33'd0, a} + {1'b0, b};
      return (t > 65'hFFFF_FFFF) ? '1 : t[COUNT_W-1:0];
   endfunction

   // Last usable slot under the current configuration.
   function automatic bit [INDEX_W-1:0] last_slot_index();
      return (last_index > DEF_BUCKET_SLOTS - 1) ? INDEX_W'(DEF_BUCKET_SLOTS - 1) : last_index;
   endfunction

   function automatic void clear_histogram();
      foreach (slot_count[i]) slot_count[i] = '0;
      recorded_total = '0;
      overflow_total = '0;
      sample_total   = '0;
      min_seen       = '1;
      max_seen       = '0;
      bucket_width   = 32'd1;
      last_index     = 8'd255;
   endfunction

   // Bins one sample; a bin past the last slot adds its rounded weight there.
   function automatic void bin_sample(bit [SAMPLE_W-1:0] s);
      bit [63:0]        p;
      bit [63:0]        bin;
      bit [63:0]        n;
      bit [INDEX_W-1:0] last;
      p    = (bucket_width == 0) ? 64'd1 : {32'd0, bucket_width};
      bin  = ({16'd0, s} * 2 + p) / (2 * p);
      last = last_slot_index();
      if (s > max_seen) max_seen = s;
      if (s < min_seen) min_seen = s;
      sample_total   = sample_total + {16'd0, s};
      recorded_total = sat_add(recorded_total, 64'd1);
      if (bin <= last) begin
         slot_count[bin[INDEX_W-1:0]] = sat_add(slot_count[bin[INDEX_W-1:0]], 64'd1);
      end else begin
         n = {56'd0, last} + 64'd1;
         overflow_total   = sat_add(overflow_total, 64'd1);
         slot_count[last] = sat_add(slot_count[last], (2 * bin + n) / (2 * n));
      end
   endfunction

   // First slot whose running count reaches half the recorded samples.
   function automatic bit [INDEX_W-1:0] median_slot();
      bit [63:0] half;
      bit [63:0] acc;
      int        last;
      half = {32'd0, recorded_total} / 2;
      acc  = '0;
      last = int'(last_slot_index());
      for (int i = 0; i <= last; i++) begin
         acc += 64'(slot_count[i]);
         if (acc >= half) return INDEX_W'(i);
      end
      return '0;
   endfunction

   // Applies one accepted transaction and queues the response it should produce.
   function automatic void histogram_apply(cmd_type c, bit [SAMPLE_W-1:0] s,
                                           bit [INDEX_W-1:0] idx);
      hist_reply_t r;
      r = '0;
      case (c)
         CMD_RECORD: begin
            bin_sample(s);
         end
         CMD_READ: begin
            if (idx <= last_slot_index()) r.bucket_count = slot_count[idx];
            pending_replies.push_back(r);
         end
         CMD_STATS: begin
            r.sample_count   = recorded_total;
            r.overflow_count = overflow_total;
            r.sample_sum     = sample_total;
            r.min_sample     = min_seen;
            r.max_sample     = max_seen;
            r.median_bucket  = median_slot();
            pending_replies.push_back(r);
         end
         default: begin
         end
      endcase
   endfunction

   // Mostly short gaps, a few long ones, none while the flow is steady.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(15, 70);
   endfunction

   // Sends one request and waits for its transaction.
   task automatic send_item(cmd_type c, bit [SAMPLE_W-1:0] s, bit [INDEX_W-1:0] idx);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= {idx, s};
      do @(posedge clock); while (req_tready !== 1'b1);
      histogram_apply(c, s, idx);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Writes one register once the block has gone quiet.
   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, bit [SPB_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (addr == REG_SPB) bucket_width = value;
      else last_index = value[INDEX_W-1:0];
   endtask

   // Response side back-pressure.
   initial begin : rsp_pacing
      int stall;
      forever begin
         @(posedge clock);
         stall = pick_gap();
         if (stall == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic void check_field(string what, bit [63:0] want, logic [63:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endfunction

   // Each response transaction is compared with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      hist_reply_t want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_replies.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %0h", $time, rsp_tdata);
         end else begin
            want = pending_replies.pop_front();
            check_field("bucket_count", 64'(want.bucket_count), 64'(rsp_tdata[31:0]));
            check_field("sample_count", 64'(want.sample_count), 64'(rsp_tdata[63:32]));
            check_field("overflow_count", 64'(want.overflow_count),
                        64'(rsp_tdata[95:64]));
            check_field("sample_sum", want.sample_sum, rsp_tdata[159:96]);
            check_field("min_sample", 64'(want.min_sample), 64'(rsp_tdata[207:160]));
            check_field("max_sample", 64'(want.max_sample), 64'(rsp_tdata[255:208]));
            check_field("median_bucket", 64'(want.median_bucket),
                        64'(rsp_tdata[263:256]));
         end
      end
   end

   // Watchdog on cycles in which no transaction happens.
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Reports on an empty histogram, including the slot at the top.
   task automatic test_empty_report();
      send_item(CMD_STATS, '0, '0);
      send_item(CMD_READ, '0, 8'd0);
      send_item(CMD_READ, '0, 8'd255);
   endtask

   // Smallest and largest samples; the largest overflows and saturates the top slot.
   task automatic test_sample_extremes();
      send_item(CMD_RECORD, '0, '0);
      send_item(CMD_RECORD, '1, '0);
      send_item(CMD_RECORD, 48'd1, '0);
      send_item(CMD_RECORD, 48'd254, '0);
      send_item(CMD_NONE, 48'd77, 8'd1);
      send_item(CMD_READ, '0, 8'd1);
      send_item(CMD_READ, '0, 8'd255);
      send_item(CMD_STATS, '0, '0);
   endtask

   // Rounding half up at a bucket width of four, then a zero width acting as one.
   task automatic test_bucket_rounding();
      write_reg(REG_SPB, 32'd4);
      send_item(CMD_RECORD, 48'd1, '0);
      send_item(CMD_RECORD, 48'd2, '0);
      send_item(CMD_RECORD, 48'd5, '0);
      send_item(CMD_RECORD, 48'd6, '0);
      send_item(CMD_READ, '0, 8'd1);
      send_item(CMD_READ, '0, 8'd2);
      write_reg(REG_SPB, 32'd0);
      send_item(CMD_RECORD, 48'd7, '0);
      send_item(CMD_READ, '0, 8'd7);
   endtask

   // A single slot takes every nonzero bin, weighted by the bin; reads past it give zero,
   // and slots hidden by shrinking come back once the range grows again.
   task automatic test_last_slot();
      write_reg(REG_NB, 32'd0);
      send_item(CMD_RECORD, 48'd3, '0);
      send_item(CMD_READ, '0, 8'd0);
      send_item(CMD_READ, '0, 8'd1);
      send_item(CMD_STATS, '0, '0);
      write_reg(REG_NB, 32'd255);
      send_item(CMD_READ, '0, 8'd254);
   endtask

   // Random traffic under one configuration; samples mostly land near the slots.
   task automatic test_random_phase(bit [SPB_W-1:0] spb, bit [INDEX_W-1:0] nb, int count,
                                    bit steady);
      int               done;
      int               r;
      int               pick;
      cmd_type          c;
      bit [63:0]        p;
      bit [63:0]        bin;
      bit [63:0]        s64;
      bit [INDEX_W-1:0] idx;
      write_reg(REG_SPB, spb);
      write_reg(REG_NB, {24'd0, nb});
      steady_flow = steady;
      done = 0;
      while (done < count) begin
         r = $urandom_range(0, 99);
         c = (r < 58) ? CMD_RECORD : (r < 80) ? CMD_READ : (r < 95) ? CMD_STATS : CMD_NONE;
         p = (bucket_width == 0) ? 64'd1 : {32'd0, bucket_width};
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            bin = 64'($urandom_range(0, int'(last_index) + int'(last_index) / 4 + 2));
            s64 = bin * p + ((p > 1) ? {32'd0, $urandom_range(0, 32'(p - 1))} : 64'd0);
         end else if (pick < 9) begin
            s64 = {$urandom, $urandom};
         end else begin
            s64 = 64'($urandom_range(0, 3));
         end
         if ($urandom_range(0, 9) < 7) idx = INDEX_W'($urandom_range(0,
                                                (last_index == 255) ? 255 : last_index + 1));
         else idx = INDEX_W'($urandom_range(0, 255));
         send_item(c, s64[SAMPLE_W-1:0], idx);
         if (c != CMD_NONE) done++;
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      clear_histogram();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_empty_report();
      test_sample_extremes();
      test_bucket_rounding();
      test_last_slot();

      test_random_phase(32'd1, 8'd255, 90, 1'b0);
      test_random_phase(32'd16, 8'd15, 90, 1'b0);
      test_random_phase(32'd0, 8'd1, 90, 1'b1);
      test_random_phase(32'hFFFF_FFFF, 8'd255, 90, 1'b0);
      test_random_phase(32'd1000, 8'd0, 80, 1'b0);
      test_random_phase(32'd3, 8'd64, 90, 1'b0);
      test_random_phase($urandom, 8'($urandom_range(1, 254)), 90, 1'b0);
      test_random_phase(32'd7, 8'd200, 70, 1'b1);

      // Drain the outstanding responses, then let the block settle.
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
